### sv/averaged_pi_duty_regulator_assert.svh
// Assertion macros used by the regulator RTL.
`ifndef AVERAGED_PI_DUTY_REGULATOR_ASSERT_SVH
`define AVERAGED_PI_DUTY_REGULATOR_ASSERT_SVH

// Implication in the same cycle, disabled during reset.
`define APDR_ASSERT_IMPL(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("regulator assertion failed");

// Implication into the next cycle, disabled during reset.
`define APDR_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("regulator assertion failed");

`endif

### sv/apdr_pkg.sv
`default_nettype none

package apdr_pkg;

    // Averaging ring.
    localparam int AVG_DEPTH  = 16;
    localparam int AVG_IDX_W  = (AVG_DEPTH > 1) ? $clog2(AVG_DEPTH) : 1;
    localparam int SAMPLE_W   = 12;
    localparam int SUM_W      = SAMPLE_W + $clog2(AVG_DEPTH);

    // Startup window.
    localparam int STARTUP_STEPS = 50;
    localparam int CNT_W         = 6;

    // Fixed point constants, Q15.16.
    localparam int ONE_Q16       = 65536;
    localparam int DUTY_MAX_Q16  = 96 * ONE_Q16;
    localparam int DUTY_SHOT_Q16 = 1 * ONE_Q16;
    localparam int DUTY_INIT_Q16 = 30 * ONE_Q16;
    localparam int ERR_INIT_Q16  = ONE_Q16;
    localparam int DUTY_OUT_W    = 23;

    // Shared multiplier.
    localparam int MUL_W  = 33;
    localparam int PROD_W = 2 * MUL_W;

    // Division of the duty share by 100 percent in Q16: round half, then a
    // reciprocal multiply by ceil(2^30 / 100) on the upper bits.
    localparam int SHARE_HALF = 50 * ONE_Q16;
    localparam int DIV_SHIFT  = 30;
    localparam int RECIP_W    = 24;
    localparam logic [RECIP_W-1:0] DIV_RECIP =
        RECIP_W'(((64'd1 << DIV_SHIFT) + 64'd99) / 64'd100);

    // Configuration port.
    localparam int CFG_ADDR_W = 5;
    localparam int CFG_DATA_W = 32;

    typedef enum logic [2:0] {
        REG_TARGET = 3'd0,
        REG_GAIN   = 3'd1,
        REG_OFFSET = 3'd2,
        REG_KP     = 3'd3,
        REG_KI     = 3'd4,
        REG_PERIOD = 3'd5
    } cfg_reg_t;

    typedef struct packed {
        logic signed [31:0] target_level;
        logic [31:0]        cal_gain;
        logic signed [31:0] cal_offset;
        logic [30:0]        prop_gain;
        logic [30:0]        integ_gain;
        logic [15:0]        pwm_period;
    } cfg_t;

endpackage

`default_nettype wire

### sv/apdr_cfg.sv
`default_nettype none

module apdr_cfg (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [apdr_pkg::CFG_ADDR_W-1:0] paddr,
    input  wire logic [apdr_pkg::CFG_DATA_W-1:0] pwdata,
    output logic      [apdr_pkg::CFG_DATA_W-1:0] prdata,
    output logic                             pready,
    output apdr_pkg::cfg_t                   cfg
);
    import apdr_pkg::*;

    cfg_t     cfg_reg;
    cfg_t     cfg_next;
    cfg_reg_t reg_sel;
    logic     wr_en;

    assign pready  = 1'b1;
    assign reg_sel = cfg_reg_t'(paddr[CFG_ADDR_W-1:2]);
    assign wr_en   = psel && penable && pwrite && pready;
    assign cfg     = cfg_reg;

    // Register write decode; unknown addresses are ignored.
    always_comb begin
        cfg_next = cfg_reg;
        if (wr_en) begin
            unique case (reg_sel)
                REG_TARGET: cfg_next.target_level = $signed(pwdata);
                REG_GAIN:   cfg_next.cal_gain     = pwdata;
                REG_OFFSET: cfg_next.cal_offset   = $signed(pwdata);
                REG_KP:     cfg_next.prop_gain    = pwdata[30:0];
                REG_KI:     cfg_next.integ_gain   = pwdata[30:0];
                REG_PERIOD: cfg_next.pwm_period   = pwdata[15:0];
                default:    cfg_next = cfg_reg;
            endcase
        end
    end

    // Register read decode.
    always_comb begin
        unique case (reg_sel)
            REG_TARGET: prdata = cfg_reg.target_level;
            REG_GAIN:   prdata = cfg_reg.cal_gain;
            REG_OFFSET: prdata = cfg_reg.cal_offset;
            REG_KP:     prdata = {1'b0, cfg_reg.prop_gain};
            REG_KI:     prdata = {1'b0, cfg_reg.integ_gain};
            REG_PERIOD: prdata = {16'd0, cfg_reg.pwm_period};
            default:    prdata = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.target_level <= 32'sd6554;
            cfg_reg.cal_gain     <= 32'd205080;
            cfg_reg.cal_offset   <= -32'sd8261;
            cfg_reg.prop_gain    <= 31'd3276800;
            cfg_reg.integ_gain   <= 31'd13107;
            cfg_reg.pwm_period   <= 16'd600;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

`default_nettype wire

### sv/apdr_ring.sv
`default_nettype none

module apdr_ring (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          shift_en,
    input  wire logic [apdr_pkg::SAMPLE_W-1:0] sample,
    output logic      [apdr_pkg::SUM_W-1:0]    ring_sum
);
    import apdr_pkg::*;

    logic [SAMPLE_W-1:0]  ring_reg [AVG_DEPTH];
    logic [AVG_IDX_W-1:0] idx_reg;
    logic [AVG_IDX_W-1:0] idx_next;
    logic [SUM_W-1:0]     sum_reg;
    logic [SUM_W-1:0]     sum_next;

    assign ring_sum = sum_reg;

    // The oldest sample leaves the sum as the new one enters.
    always_comb begin
        sum_next = sum_reg - SUM_W'(ring_reg[idx_reg]) + SUM_W'(sample);
        if (idx_reg == AVG_IDX_W'(AVG_DEPTH - 1)) begin
            idx_next = '0;
        end else begin
            idx_next = idx_reg + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < AVG_DEPTH; i++) begin
                ring_reg[i] <= '0;
            end
            idx_reg <= '0;
            sum_reg <= '0;
        end else if (shift_en) begin
            ring_reg[idx_reg] <= sample;
            idx_reg           <= idx_next;
            sum_reg           <= sum_next;
        end
    end

endmodule

`default_nettype wire

### sv/apdr_mul.sv
`default_nettype none

module apdr_mul (
    input  wire logic                              aclk,
    input  wire logic                              mul_en,
    input  wire logic signed [apdr_pkg::MUL_W-1:0] op_a,
    input  wire logic signed [apdr_pkg::MUL_W-1:0] op_b,
    output logic signed      [apdr_pkg::PROD_W-1:0] prod
);
    import apdr_pkg::*;

    logic signed [PROD_W-1:0] prod_reg;

    assign prod = prod_reg;

    // Signed multiply with a registered product, held while idle.
    always_ff @(posedge aclk) begin
        if (mul_en) begin
            prod_reg <= op_a * op_b;
        end
    end

endmodule

`default_nettype wire

### sv/averaged_pi_duty_regulator.sv
// Averaged incremental PI duty regulator. Each accepted word is one 12-bit
// converter sample; it enters a ring of the last 16 samples whose running sum
// is calibrated by one gain and one offset, compared with the target, and fed
// to an incremental PI step whose duty is clamped to 0..96 percent (with a
// one-shot drop to 1 percent on an overshoot during the first steps after
// reset). The result word carries the PWM compare value, the duty and the
// error. The input is not ready while a word is in progress: a new word is
// accepted only once the last result is loaded into the output register,
// which waits for the receiver. The single 33x33 signed multiplier is shared
// by a nine-step sequencer that uses it five times per word. Configuration
// registers sit on the APB port at byte address 4*i; the user must see that
// they are written only while idle, which the block does not enforce.
`default_nettype none

module averaged_pi_duty_regulator (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    // Input words.
    input  wire logic                            s_valid,
    output logic                                 s_ready,
    input  wire logic [apdr_pkg::SAMPLE_W-1:0]   s_adc_sample,
    // Result words.
    output logic                                 m_valid,
    input  wire logic                            m_ready,
    output logic [15:0]                          m_pwm_compare,
    output logic [apdr_pkg::DUTY_OUT_W-1:0]      m_duty_percent,
    output logic signed [31:0]                   m_control_error,
    // Configuration port.
    input  wire logic                            psel,
    input  wire logic                            penable,
    input  wire logic                            pwrite,
    input  wire logic [apdr_pkg::CFG_ADDR_W-1:0] paddr,
    input  wire logic [apdr_pkg::CFG_DATA_W-1:0] pwdata,
    output logic [apdr_pkg::CFG_DATA_W-1:0]      prdata,
    output logic                                 pready
);
    import apdr_pkg::*;

    `include "averaged_pi_duty_regulator_assert.svh"

    // Derived widths of the datapath.
    localparam int MP_W     = SUM_W + 32;
    localparam int MR_W     = MP_W - 15;
    localparam int EW       = MR_W + 3;
    localparam int RND_W    = PROD_W - 16;
    localparam int DUTY_W   = RND_W + 2;
    localparam int SHARE_PW = DUTY_OUT_W + 17;
    localparam int M_W      = SHARE_PW - 16;

    localparam logic signed [DUTY_W-1:0] DUTY_MAX_W  = DUTY_W'(DUTY_MAX_Q16);
    localparam logic signed [DUTY_W-1:0] DUTY_SHOT_W = DUTY_W'(DUTY_SHOT_Q16);

    typedef enum logic [9:0] {
        ST_IDLE  = 10'b00_0000_0001,
        ST_RING  = 10'b00_0000_0010,
        ST_MEAS  = 10'b00_0000_0100,
        ST_ERR   = 10'b00_0000_1000,
        ST_PDIFF = 10'b00_0001_0000,
        ST_INTEG = 10'b00_0010_0000,
        ST_DUTY  = 10'b00_0100_0000,
        ST_SHARE = 10'b00_1000_0000,
        ST_SCALE = 10'b01_0000_0000,
        ST_OUT   = 10'b10_0000_0000
    } state_t;

    cfg_t                      cfg;
    state_t                    state_reg, state_next;
    logic [SAMPLE_W-1:0]       sample_reg;
    logic [SUM_W-1:0]          ring_sum;
    logic                      ring_shift;
    logic                      mul_en;
    logic signed [MUL_W-1:0]   op_a, op_b;
    logic signed [PROD_W-1:0]  mul_prod;

    logic signed [31:0]        err_reg, err_next;
    logic signed [31:0]        prev_err_reg, prev_err_next;
    logic [DUTY_OUT_W-1:0]     accum_reg, accum_next;
    logic signed [DUTY_W-1:0]  p_acc_reg, p_acc_next;
    logic [CNT_W-1:0]          start_cnt_reg, start_cnt_next;

    logic                      m_valid_reg, m_valid_next;
    logic [15:0]               compare_reg, compare_next;
    logic [DUTY_OUT_W-1:0]     duty_out_reg, duty_out_next;
    logic signed [31:0]        err_out_reg, err_out_next;

    logic [MP_W:0]             meas_rnd_full;
    logic [MR_W-1:0]           meas_rnd;
    logic signed [EW-1:0]      err_wide;
    logic signed [32:0]        err_diff;
    logic signed [PROD_W-1:0]  rnd_sum;
    logic signed [RND_W-1:0]   rnd_val;
    logic signed [DUTY_W-1:0]  duty_wide;
    logic [SHARE_PW-1:0]       share_sum;
    logic [M_W-1:0]            share_m;
    logic [15:0]               share_q;

    apdr_cfg u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    apdr_ring u_ring (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .shift_en (ring_shift),
        .sample   (sample_reg),
        .ring_sum (ring_sum)
    );

    apdr_mul u_mul (
        .aclk   (aclk),
        .mul_en (mul_en),
        .op_a   (op_a),
        .op_b   (op_b),
        .prod   (mul_prod)
    );

    assign s_ready         = (state_reg == ST_IDLE);
    assign ring_shift      = (state_reg == ST_RING);
    assign m_valid         = m_valid_reg;
    assign m_pwm_compare   = compare_reg;
    assign m_duty_percent  = duty_out_reg;
    assign m_control_error = err_out_reg;

    // Measurement: round the sum-times-gain product to Q16, add the offset.
    assign meas_rnd_full = {1'b0, mul_prod[MP_W-1:0]} + (MP_W + 1)'(32768);
    assign meas_rnd      = meas_rnd_full[MP_W:16];
    assign err_wide      = EW'(cfg.target_level)
                           - ($signed(EW'(meas_rnd)) + EW'(cfg.cal_offset));

    // Error difference for the proportional term.
    assign err_diff = {err_reg[31], err_reg} - {prev_err_reg[31], prev_err_reg};

    // Shared half-up rounding of a Q16 product.
    assign rnd_sum = mul_prod + PROD_W'(32768);
    assign rnd_val = rnd_sum[PROD_W-1:16];

    assign duty_wide = p_acc_reg + DUTY_W'(rnd_val);

    // Duty share of the period: round, drop 16 bits, then divide by 100.
    assign share_sum = mul_prod[SHARE_PW-1:0] + SHARE_PW'(SHARE_HALF);
    assign share_m   = share_sum[SHARE_PW-1:16];
    assign share_q   = mul_prod[DIV_SHIFT+15:DIV_SHIFT];

    // Sequencer and datapath next state.
    always_comb begin
        state_next     = state_reg;
        err_next       = err_reg;
        prev_err_next  = prev_err_reg;
        accum_next     = accum_reg;
        p_acc_next     = p_acc_reg;
        start_cnt_next = start_cnt_reg;
        m_valid_next   = m_valid_reg;
        compare_next   = compare_reg;
        duty_out_next  = duty_out_reg;
        err_out_next   = err_out_reg;
        mul_en         = 1'b0;
        op_a           = '0;
        op_b           = '0;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    state_next = ST_RING;
                end
            end
            ST_RING: begin
                if (start_cnt_reg < CNT_W'(STARTUP_STEPS)) begin
                    start_cnt_next = start_cnt_reg + 1'b1;
                end
                state_next = ST_MEAS;
            end
            ST_MEAS: begin
                mul_en     = 1'b1;
                op_a       = $signed(MUL_W'(ring_sum));
                op_b       = $signed({1'b0, cfg.cal_gain});
                state_next = ST_ERR;
            end
            ST_ERR: begin
                // Saturate the error to 32 bits signed.
                if (&err_wide[EW-1:31] || ~|err_wide[EW-1:31]) begin
                    err_next = err_wide[31:0];
                end else if (err_wide[EW-1]) begin
                    err_next = 32'sh8000_0000;
                end else begin
                    err_next = 32'sh7FFF_FFFF;
                end
                state_next = ST_PDIFF;
            end
            ST_PDIFF: begin
                mul_en        = 1'b1;
                op_a          = err_diff;
                op_b          = $signed({2'b00, cfg.prop_gain});
                prev_err_next = err_reg;
                state_next    = ST_INTEG;
            end
            ST_INTEG: begin
                mul_en     = 1'b1;
                op_a       = MUL_W'(err_reg);
                op_b       = $signed({2'b00, cfg.integ_gain});
                p_acc_next = DUTY_W'(rnd_val) + $signed(DUTY_W'(accum_reg));
                state_next = ST_DUTY;
            end
            ST_DUTY: begin
                // Clamp, with the one-shot startup drop on overshoot.
                if (duty_wide > DUTY_MAX_W) begin
                    if (start_cnt_reg < CNT_W'(STARTUP_STEPS)) begin
                        accum_next     = DUTY_SHOT_W[DUTY_OUT_W-1:0];
                        start_cnt_next = CNT_W'(STARTUP_STEPS);
                    end else begin
                        accum_next = DUTY_MAX_W[DUTY_OUT_W-1:0];
                    end
                end else if (duty_wide < 0) begin
                    accum_next = '0;
                end else begin
                    accum_next = duty_wide[DUTY_OUT_W-1:0];
                end
                state_next = ST_SHARE;
            end
            ST_SHARE: begin
                mul_en     = 1'b1;
                op_a       = $signed(MUL_W'(accum_reg));
                op_b       = $signed(MUL_W'(cfg.pwm_period));
                state_next = ST_SCALE;
            end
            ST_SCALE: begin
                mul_en     = 1'b1;
                op_a       = $signed(MUL_W'(share_m));
                op_b       = $signed(MUL_W'(DIV_RECIP));
                state_next = ST_OUT;
            end
            ST_OUT: begin
                // Load the result word once the output register is free.
                if (!m_valid_reg || m_ready) begin
                    m_valid_next  = 1'b1;
                    compare_next  = cfg.pwm_period - share_q;
                    duty_out_next = accum_reg;
                    err_out_next  = err_reg;
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            prev_err_reg  <= 32'(ERR_INIT_Q16);
            accum_reg     <= DUTY_OUT_W'(DUTY_INIT_Q16);
            start_cnt_reg <= '0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            prev_err_reg  <= prev_err_next;
            accum_reg     <= accum_next;
            start_cnt_reg <= start_cnt_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            sample_reg <= s_adc_sample;
        end
        err_reg      <= err_next;
        p_acc_reg    <= p_acc_next;
        compare_reg  <= compare_next;
        duty_out_reg <= duty_out_next;
        err_out_reg  <= err_out_next;
    end

    // Checks on the sequencer and the result range.
    `APDR_ASSERT_NEXT(a_busy_after_accept, aclk, aresetn, s_valid && s_ready, !s_ready)
    `APDR_ASSERT_IMPL(a_duty_in_range, aclk, aresetn, m_valid,
                      m_duty_percent <= DUTY_OUT_W'(DUTY_MAX_Q16))
    `APDR_ASSERT_IMPL(a_compare_in_period, aclk, aresetn, m_valid,
                      m_pwm_compare <= cfg.pwm_period)
    `APDR_ASSERT_IMPL(a_startup_bounded, aclk, aresetn, 1'b1,
                      start_cnt_reg <= CNT_W'(STARTUP_STEPS))

endmodule

`default_nettype wire

### sim/tb_top.sv
`default_nettype none

module tb_top;
    import apdr_pkg::*;

    localparam int SEGMENTS          = 8;
    localparam int WORDS_PER_SEGMENT = 50;
    localparam int DRAIN_CYCLES      = 16;
    localparam int MAX_REPORTS       = 10;
    localparam int RUN_LIMIT         = 2000000;

    // Register slots past the last defined register; writes there are ignored.
    localparam logic [2:0] REG_SPARE_LO = 3'd6;
    localparam logic [2:0] REG_SPARE_HI = 3'd7;

    typedef struct packed {
        logic [15:0]            pwm_compare;
        logic [DUTY_OUT_W-1:0]  duty_percent;
        logic signed [31:0]     control_error;
    } duty_result_t;

    typedef enum logic [1:0] {
        ROW_WRITE,
        ROW_SAMPLE,
        ROW_KNOWN
    } row_kind_t;

    typedef struct packed {
        row_kind_t    kind;
        logic [2:0]   reg_idx;
        logic [31:0]  value;
        duty_result_t known;
    } directed_row_t;

    // Directed walk: defaults after reset, the startup one-shot, the clamp at
    // 96 percent, both error saturations, full-scale gains, a zero period,
    // writes to unused slots, then a moderate setting at the largest period.
    localparam int N_DIRECTED = 35;
    localparam directed_row_t DIRECTED [N_DIRECTED] = '{
        '{ROW_KNOWN,  '0,           32'd0,          '{16'd600, 23'd0, 32'sd14815}},
        '{ROW_SAMPLE, '0,           32'd4095,       '0},
        '{ROW_SAMPLE, '0,           32'd4095,       '0},
        '{ROW_SAMPLE, '0,           32'd2048,       '0},
        '{ROW_SAMPLE, '0,           32'd1,          '0},
        '{ROW_WRITE,  REG_TARGET,   32'h7FFF_FFFF,  '0},
        '{ROW_WRITE,  REG_OFFSET,   32'h8000_0000,  '0},
        '{ROW_KNOWN,  '0,           32'd4095,       '{16'd594, 23'd65536, 32'h7FFF_FFFF}},
        '{ROW_KNOWN,  '0,           32'd0,          '{16'd24, 23'd6291456, 32'h7FFF_FFFF}},
        '{ROW_SAMPLE, '0,           32'd4095,       '0},
        '{ROW_WRITE,  REG_TARGET,   32'h8000_0000,  '0},
        '{ROW_WRITE,  REG_OFFSET,   32'h7FFF_FFFF,  '0},
        '{ROW_WRITE,  REG_GAIN,     32'hFFFF_FFFF,  '0},
        '{ROW_WRITE,  REG_KP,       32'hFFFF_FFFF,  '0},
        '{ROW_WRITE,  REG_KI,       32'hFFFF_FFFF,  '0},
        '{ROW_KNOWN,  '0,           32'd4095,       '{16'd600, 23'd0, 32'h8000_0000}},
        '{ROW_KNOWN,  '0,           32'd0,          '{16'd600, 23'd0, 32'h8000_0000}},
        '{ROW_WRITE,  REG_PERIOD,   32'hFFFF_0000,  '0},
        '{ROW_WRITE,  REG_SPARE_LO, 32'h1234_5678,  '0},
        '{ROW_WRITE,  REG_SPARE_HI, 32'hFFFF_FFFF,  '0},
        '{ROW_KNOWN,  '0,           32'd2048,       '{16'd0, 23'd0, 32'h8000_0000}},
        '{ROW_WRITE,  REG_PERIOD,   32'h0000_FFFF,  '0},
        '{ROW_WRITE,  REG_TARGET,   32'd150000,     '0},
        '{ROW_WRITE,  REG_GAIN,     32'd205080,     '0},
        '{ROW_WRITE,  REG_OFFSET,   32'd0,          '0},
        '{ROW_WRITE,  REG_KP,       32'd131072,     '0},
        '{ROW_WRITE,  REG_KI,       32'd6554,       '0},
        '{ROW_SAMPLE, '0,           32'd0,          '0},
        '{ROW_SAMPLE, '0,           32'd4095,       '0},
        '{ROW_SAMPLE, '0,           32'd1,          '0},
        '{ROW_SAMPLE, '0,           32'd4094,       '0},
        '{ROW_SAMPLE, '0,           32'd2048,       '0},
        '{ROW_SAMPLE, '0,           32'd2730,       '0},
        '{ROW_SAMPLE, '0,           32'd1365,       '0},
        '{ROW_SAMPLE, '0,           32'd3000,       '0}
    };

    logic                   aclk = 1'b0;
    logic                   aresetn = 1'b0;
    logic                   s_valid = 1'b0;
    logic                   s_ready;
    logic [SAMPLE_W-1:0]    s_adc_sample = '0;
    logic                   m_valid;
    logic                   m_ready = 1'b0;
    logic [15:0]            m_pwm_compare;
    logic [DUTY_OUT_W-1:0]  m_duty_percent;
    logic signed [31:0]     m_control_error;
    logic                   psel = 1'b0;
    logic                   penable = 1'b0;
    logic                   pwrite = 1'b0;
    logic [CFG_ADDR_W-1:0]  paddr = '0;
    logic [CFG_DATA_W-1:0]  pwdata = '0;
    logic [CFG_DATA_W-1:0]  prdata;
    logic                   pready;

    // Regulator state and register copy kept alongside the block.
    logic [SAMPLE_W-1:0]    window_ring [AVG_DEPTH];
    logic [SUM_W-1:0]       window_sum;
    logic [AVG_IDX_W-1:0]   window_pos;
    logic signed [31:0]     last_error;
    logic signed [31:0]     duty_held;
    logic [CNT_W-1:0]       steps_seen;
    cfg_t                   regs;

    duty_result_t           expected_duty_q [$];
    int                     mismatch_count = 0;
    int                     burst_left = 0;
    logic [5:0]             stall_phase = '0;

    averaged_pi_duty_regulator dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_adc_sample    (s_adc_sample),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_pwm_compare   (m_pwm_compare),
        .m_duty_percent  (m_duty_percent),
        .m_control_error (m_control_error),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    function automatic void reset_regulator_state();
        foreach (window_ring[i]) window_ring[i] = '0;
        window_sum          = '0;
        window_pos          = '0;
        last_error          = ERR_INIT_Q16;
        duty_held           = DUTY_INIT_Q16;
        steps_seen          = '0;
        regs.target_level   = 32'sd6554;
        regs.cal_gain       = 32'd205080;
        regs.cal_offset     = -32'sd8261;
        regs.prop_gain      = 31'd3276800;
        regs.integ_gain     = 31'd13107;
        regs.pwm_period     = 16'd600;
    endfunction

    function automatic void store_reg(logic [2:0] idx, logic [31:0] value);
        case (idx)
            REG_TARGET: regs.target_level = value;
            REG_GAIN:   regs.cal_gain     = value;
            REG_OFFSET: regs.cal_offset   = value;
            REG_KP:     regs.prop_gain    = value[30:0];
            REG_KI:     regs.integ_gain   = value[30:0];
            REG_PERIOD: regs.pwm_period   = value[15:0];
            default: ;
        endcase
    endfunction

    // One control step: average, calibrate, incremental PI, clamp, compare value.
    function automatic duty_result_t predict_duty_step(logic [SAMPLE_W-1:0] sample);
        logic [63:0]        prod;
        logic [63:0]        rounded;
        logic signed [79:0] meas;
        logic signed [79:0] err_wide;
        logic signed [31:0] err_sat;
        logic signed [79:0] err80;
        logic signed [79:0] prev80;
        logic signed [79:0] kp80;
        logic signed [79:0] ki80;
        logic signed [79:0] p_term;
        logic signed [79:0] i_term;
        logic signed [79:0] duty_next;
        logic [31:0]        duty_clamped;
        logic [63:0]        share;
        duty_result_t       res;

        window_sum = window_sum - window_ring[window_pos] + sample;
        window_ring[window_pos] = sample;
        window_pos = (window_pos == AVG_DEPTH - 1) ? '0 : window_pos + 1'b1;
        if (steps_seen < STARTUP_STEPS)
            steps_seen = steps_seen + 1'b1;

        prod = 64'(window_sum) * 64'(regs.cal_gain);
        rounded = (prod + 64'd32768) >> 16;
        meas = $signed({16'd0, rounded}) + $signed(regs.cal_offset);
        err_wide = $signed(regs.target_level) - meas;
        if (err_wide > 80'sd2147483647)
            err_sat = 32'sh7FFF_FFFF;
        else if (err_wide < -80'sd2147483648)
            err_sat = 32'sh8000_0000;
        else
            err_sat = err_wide[31:0];

        // Both terms round half up, i.e. floor of value plus one half.
        err80  = err_sat;
        prev80 = last_error;
        kp80   = {49'd0, regs.prop_gain};
        ki80   = {49'd0, regs.integ_gain};
        p_term = ((err80 - prev80) * kp80 + 80'sd32768) >>> 16;
        i_term = (err80 * ki80 + 80'sd32768) >>> 16;
        duty_next = duty_held + p_term + i_term;
        last_error = err_sat;

        // An overshoot inside the startup window drops to one percent once.
        if (duty_next > DUTY_MAX_Q16) begin
            if (steps_seen < STARTUP_STEPS) begin
                duty_clamped = DUTY_SHOT_Q16;
                steps_seen = STARTUP_STEPS;
            end else begin
                duty_clamped = DUTY_MAX_Q16;
            end
        end else if (duty_next < 0) begin
            duty_clamped = '0;
        end else begin
            duty_clamped = duty_next[31:0];
        end
        duty_held = duty_clamped;

        share = (64'(duty_clamped) * 64'(regs.pwm_period) + 64'(SHARE_HALF))
                / (64'd100 * 64'(ONE_Q16));
        res.pwm_compare   = regs.pwm_period - share[15:0];
        res.duty_percent  = duty_clamped[DUTY_OUT_W-1:0];
        res.control_error = err_sat;
        return res;
    endfunction

    // Setup cycle, then access cycle; the register takes the value at the
    // edge that completes the access.
    task automatic write_reg(input logic [2:0] idx, input logic [31:0] value);
        @(negedge aclk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = {idx, 2'b00};
        pwdata  = value;
        @(negedge aclk);
        penable = 1'b1;
        do @(posedge aclk); while (!pready);
        store_reg(idx, value);
        @(negedge aclk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    // Offer one sample word in bursts with random gaps between them.
    task automatic send_sample(input logic [SAMPLE_W-1:0] sample, input bit use_known,
                               input duty_result_t known);
        duty_result_t predicted;
        int gap;

        @(negedge aclk);
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 24);
            if (gap > 0) begin
                s_valid = 1'b0;
                repeat (gap) @(negedge aclk);
            end
            burst_left = $urandom_range(1, 30);
        end
        s_valid      = 1'b1;
        s_adc_sample = sample;
        do @(posedge aclk); while (!s_ready);
        predicted = predict_duty_step(sample);
        expected_duty_q.push_back(use_known ? known : predicted);
        burst_left--;
    endtask

    // Stop offering words and let every outstanding result come back.
    task automatic settle();
        @(negedge aclk);
        s_valid = 1'b0;
        burst_left = 0;
        while (expected_duty_q.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic load_random_settings();
        write_reg(REG_TARGET, ($urandom_range(0, 5) == 0) ? $urandom
                              : 32'(int'($urandom_range(0, 500000)) - 100000));
        write_reg(REG_GAIN, ($urandom_range(0, 5) == 0) ? $urandom
                            : 32'($urandom_range(100000, 400000)));
        write_reg(REG_OFFSET, ($urandom_range(0, 5) == 0) ? $urandom
                              : 32'(int'($urandom_range(0, 40000)) - 20000));
        write_reg(REG_KP, ($urandom_range(0, 5) == 0) ? $urandom
                          : 32'($urandom_range(0, 1 << 20)));
        write_reg(REG_KI, ($urandom_range(0, 5) == 0) ? $urandom
                          : 32'($urandom_range(0, 1 << 16)));
        case ($urandom_range(0, 15))
            0:       write_reg(REG_PERIOD, 32'd0);
            1, 2:    write_reg(REG_PERIOD, $urandom);
            default: write_reg(REG_PERIOD, 32'($urandom_range(1, 65535)));
        endcase
        if ($urandom_range(0, 3) == 0)
            write_reg($urandom_range(0, 1) ? REG_SPARE_LO : REG_SPARE_HI, $urandom);
    endtask

    // Mostly a steady level with noise, plus uniform values and full-scale hits.
    function automatic logic [SAMPLE_W-1:0] pick_sample(logic [SAMPLE_W-1:0] level);
        int unsigned roll;
        int v;

        roll = $urandom_range(0, 9);
        if (roll < 3)
            return SAMPLE_W'($urandom_range(0, 4095));
        if (roll < 5)
            return roll[0] ? '1 : '0;
        v = int'(level) + int'($urandom_range(0, 64)) - 32;
        if (v < 0)
            v = 0;
        if (v > 4095)
            v = 4095;
        return SAMPLE_W'(v);
    endfunction

    task automatic log_fault(input bit unexpected, input duty_result_t want,
                             input duty_result_t got);
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS) begin
            if (unexpected)
                $display("result word with none pending: compare %0d duty %0d error %0d",
                         got.pwm_compare, got.duty_percent, got.control_error);
            else
                $display("result mismatch: compare %0d/%0d duty %0d/%0d error %0d/%0d %s",
                         want.pwm_compare, got.pwm_compare, want.duty_percent,
                         got.duty_percent, want.control_error, got.control_error,
                         "(expected/actual)");
        end
    endtask

    // Compare each accepted result word with the oldest prediction.
    always @(posedge aclk) begin : check_results
        duty_result_t want;
        duty_result_t got;

        if (aresetn && m_valid && m_ready) begin
            got = '{m_pwm_compare, m_duty_percent, m_control_error};
            if (expected_duty_q.size() == 0) begin
                log_fault(1'b1, '0, got);
            end else begin
                want = expected_duty_q.pop_front();
                if (got !== want)
                    log_fault(1'b0, want, got);
            end
        end
    end

    // Receiver: always ready, random stalls, a regular on/off pattern, coin flips.
    always @(negedge aclk) begin
        stall_phase <= stall_phase + 1'b1;
        case (stall_phase[5:4])
            2'd0:    m_ready <= 1'b1;
            2'd1:    m_ready <= ($urandom_range(0, 3) != 0);
            2'd2:    m_ready <= stall_phase[2];
            default: m_ready <= ($urandom_range(0, 1) != 0);
        endcase
    end

    initial begin
        #(RUN_LIMIT);
        $display("FAIL averaged_pi_duty_regulator");
        $finish;
    end

    initial begin : stimulus
        logic [SAMPLE_W-1:0] level;
        bit in_flight;

        reset_regulator_state();
        in_flight = 1'b0;
        repeat (10) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // Directed table; register writes wait until the block has drained.
        for (int i = 0; i < N_DIRECTED; i++) begin
            case (DIRECTED[i].kind)
                ROW_WRITE: begin
                    if (in_flight)
                        settle();
                    in_flight = 1'b0;
                    write_reg(DIRECTED[i].reg_idx, DIRECTED[i].value);
                end
                ROW_KNOWN: begin
                    send_sample(DIRECTED[i].value[SAMPLE_W-1:0], 1'b1, DIRECTED[i].known);
                    in_flight = 1'b1;
                end
                default: begin
                    send_sample(DIRECTED[i].value[SAMPLE_W-1:0], 1'b0, '0);
                    in_flight = 1'b1;
                end
            endcase
        end

        // Random segments, each under a fresh register setting.
        for (int seg = 0; seg < SEGMENTS; seg++) begin
            settle();
            load_random_settings();
            level = SAMPLE_W'($urandom_range(0, 4095));
            repeat (WORDS_PER_SEGMENT) send_sample(pick_sample(level), 1'b0, '0);
        end
        settle();

        if (mismatch_count == 0 && expected_duty_q.size() == 0)
            $display("PASS averaged_pi_duty_regulator");
        else
            $display("FAIL averaged_pi_duty_regulator");
        $finish;
    end

endmodule

`default_nettype wire

### files.f
+incdir+sv
sv/apdr_pkg.sv
sv/apdr_cfg.sv
sv/apdr_ring.sv
sv/apdr_mul.sv
sv/averaged_pi_duty_regulator.sv
sim/tb_top.sv
